// ----- design/btta_pkg.sv -----
package btta_pkg;

    // Default store depth and tag overhead per block
    localparam int STORE_WORDS_DEF = 1024;
    localparam int ADMIN_WORDS     = 2;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int SIZE_W  = 11;
    localparam int ADDR_W  = 10;
    localparam int TOT_W   = 11;
    localparam int LARGE_W = 10;
    localparam int HOLE_W  = 10;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] block_addr;
    } btta_in_t;

    typedef struct packed {
        logic               status;
        logic [ADDR_W-1:0]  alloc_addr;
        logic [TOT_W-1:0]   free_total;
        logic [LARGE_W-1:0] largest_usable;
        logic [HOLE_W-1:0]  hole_count;
        logic [TOT_W-1:0]   used_total;
        logic [TOT_W-1:0]   admin_total;
    } btta_out_t;

    // Read address sources
    typedef enum logic [3:0] {
        RS_LO,
        RS_LO_ADV,
        RS_HI,
        RS_HI_ADV,
        RS_START,
        RS_END,
        RS_START_M1,
        RS_START_MRG,
        RS_END_P1,
        RS_END_MRG
    } rsel_t;

    // Write address and data sources
    typedef enum logic [3:0] {
        WS_NONE,
        WS_CLEAR,
        WS_INIT_LO,
        WS_INIT_HI,
        WS_FAR,
        WS_END2,
        WS_BASE,
        WS_END,
        WS_START_NEG,
        WS_START_MERGE,
        WS_END_SVAL,
        WS_END_MERGE,
        WS_START_SVAL
    } wsel_t;

    // Kind of result to load
    typedef enum logic [1:0] {
        FIN_OK,
        FIN_FAIL,
        FIN_ALLOC,
        FIN_QUERY
    } fin_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALO_START,
        ST_ALO_EV,
        ST_AHI_EV,
        ST_AHI_TAIL,
        ST_DECIDE,
        ST_AW_FAR,
        ST_AW_END2,
        ST_AW_BASE,
        ST_AW_END,
        ST_Q_START,
        ST_Q_EV,
        ST_F_START,
        ST_F_TSTART,
        ST_F_CHKEND,
        ST_F_TEND,
        ST_F_PREV,
        ST_F_PREV_EV,
        ST_F_MRG_LO,
        ST_F_WEND,
        ST_F_NEXT_EV,
        ST_F_MRG_HI,
        ST_F_WSTART,
        ST_I_LO,
        ST_I_HI,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        rsel_t rsel;
        wsel_t wsel;
        logic  load_in;
        logic  lo_step;
        logic  hi_step;
        logic  tlo_cap;
        logic  thi_cap;
        logic  decide;
        logic  tval_cap;
        logic  start_mrg;
        logic  end_mrg;
        logic  q_acc;
        logic  clr_step;
        logic  fin_load;
        fin_t  fin;
    } btta_cmd_t;

    typedef struct packed {
        logic fit;
        logic lo_adv_ge_n;
        logic hi_adv_le0;
        logic rd_neg;
        logic rd_lt2;
        logic rd_ne_tval;
        logic size_bad;
        logic addr_bad;
        logic end_ge_n;
        logic start_pos;
        logic end_lt_last;
        logic split;
        logic out_free;
        logic clr_last;
    } btta_sts_t;

endpackage

// ----- design/btta_ram.sv -----
module btta_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/btta_ctrl.sv -----
module btta_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  btta_pkg::action_t   action,
    input  btta_pkg::btta_sts_t sts,
    output btta_pkg::btta_cmd_t cmd
);
    import btta_pkg::*;

    ctrl_state_t state_reg, state_next;
    fin_t        fin_reg, fin_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            fin_reg   <= FIN_OK;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.rsel   = RS_LO;
        cmd.wsel   = WS_NONE;
        cmd.fin    = fin_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wsel     = WS_CLEAR;
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    case (action)
                        ACT_INIT:  state_next = ST_I_LO;
                        ACT_ALLOC: state_next = ST_ALO_START;
                        ACT_FREE:  state_next = ST_F_START;
                        ACT_QUERY: state_next = ST_Q_START;
                        default:   state_next = ST_I_LO;
                    endcase
                end
            end
            // Allocate: walk up from the bottom
            ST_ALO_START: begin
                if (sts.size_bad) begin
                    fin_next   = FIN_FAIL;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rsel   = RS_LO;
                    state_next = ST_ALO_EV;
                end
            end
            ST_ALO_EV: begin
                if (sts.fit) begin
                    cmd.tlo_cap = 1'b1;
                    cmd.rsel    = RS_HI;
                    state_next  = ST_AHI_EV;
                end else begin
                    cmd.lo_step = 1'b1;
                    cmd.rsel    = RS_LO_ADV;
                    if (sts.lo_adv_ge_n) begin
                        fin_next   = FIN_FAIL;
                        state_next = ST_FINISH;
                    end
                end
            end
            // Walk down from the top
            ST_AHI_EV: begin
                if (sts.fit) begin
                    cmd.thi_cap = 1'b1;
                    state_next  = ST_DECIDE;
                end else begin
                    cmd.hi_step = 1'b1;
                    cmd.rsel    = RS_HI_ADV;
                    if (sts.hi_adv_le0) begin
                        state_next = ST_AHI_TAIL;
                    end
                end
            end
            ST_AHI_TAIL: begin
                cmd.thi_cap = 1'b1;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_AW_FAR;
            end
            ST_AW_FAR: begin
                if (sts.split) begin
                    cmd.wsel   = WS_FAR;
                    state_next = ST_AW_END2;
                end else begin
                    state_next = ST_AW_BASE;
                end
            end
            ST_AW_END2: begin
                cmd.wsel   = WS_END2;
                state_next = ST_AW_BASE;
            end
            ST_AW_BASE: begin
                cmd.wsel   = WS_BASE;
                state_next = ST_AW_END;
            end
            ST_AW_END: begin
                cmd.wsel   = WS_END;
                fin_next   = FIN_ALLOC;
                state_next = ST_FINISH;
            end
            // Query: walk the whole chain
            ST_Q_START: begin
                cmd.rsel   = RS_LO;
                state_next = ST_Q_EV;
            end
            ST_Q_EV: begin
                cmd.q_acc   = 1'b1;
                cmd.lo_step = 1'b1;
                cmd.rsel    = RS_LO_ADV;
                if (sts.lo_adv_ge_n) begin
                    fin_next   = FIN_QUERY;
                    state_next = ST_FINISH;
                end
            end
            // Free: check tags, then merge
            ST_F_START: begin
                if (sts.addr_bad) begin
                    fin_next   = FIN_FAIL;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rsel   = RS_START;
                    state_next = ST_F_TSTART;
                end
            end
            ST_F_TSTART: begin
                cmd.tval_cap = 1'b1;
                if (sts.rd_lt2) begin
                    fin_next   = FIN_FAIL;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_F_CHKEND;
                end
            end
            ST_F_CHKEND: begin
                if (sts.end_ge_n) begin
                    fin_next   = FIN_FAIL;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rsel   = RS_END;
                    state_next = ST_F_TEND;
                end
            end
            ST_F_TEND: begin
                if (sts.rd_ne_tval) begin
                    fin_next   = FIN_FAIL;
                    state_next = ST_FINISH;
                end else begin
                    cmd.wsel   = WS_START_NEG;
                    state_next = ST_F_PREV;
                end
            end
            ST_F_PREV: begin
                if (sts.start_pos) begin
                    cmd.rsel   = RS_START_M1;
                    state_next = ST_F_PREV_EV;
                end else begin
                    state_next = ST_F_WEND;
                end
            end
            ST_F_PREV_EV: begin
                if (sts.rd_neg) begin
                    cmd.start_mrg = 1'b1;
                    cmd.rsel      = RS_START_MRG;
                    state_next    = ST_F_MRG_LO;
                end else begin
                    state_next = ST_F_WEND;
                end
            end
            ST_F_MRG_LO: begin
                cmd.wsel   = WS_START_MERGE;
                state_next = ST_F_WEND;
            end
            ST_F_WEND: begin
                cmd.wsel = WS_END_SVAL;
                if (sts.end_lt_last) begin
                    cmd.rsel   = RS_END_P1;
                    state_next = ST_F_NEXT_EV;
                end else begin
                    fin_next   = FIN_OK;
                    state_next = ST_FINISH;
                end
            end
            ST_F_NEXT_EV: begin
                if (sts.rd_neg) begin
                    cmd.end_mrg = 1'b1;
                    cmd.rsel    = RS_END_MRG;
                    state_next  = ST_F_MRG_HI;
                end else begin
                    fin_next   = FIN_OK;
                    state_next = ST_FINISH;
                end
            end
            ST_F_MRG_HI: begin
                cmd.wsel   = WS_END_MERGE;
                state_next = ST_F_WSTART;
            end
            ST_F_WSTART: begin
                cmd.wsel   = WS_START_SVAL;
                fin_next   = FIN_OK;
                state_next = ST_FINISH;
            end
            // Init: rewrite both end tags
            ST_I_LO: begin
                cmd.wsel   = WS_INIT_LO;
                state_next = ST_I_HI;
            end
            ST_I_HI: begin
                cmd.wsel   = WS_INIT_HI;
                fin_next   = FIN_OK;
                state_next = ST_FINISH;
            end
            // Hand the result over once the output slot is free
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.fin_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/btta_dp.sv -----
module btta_dp #(
    parameter int STORE_WORDS = btta_pkg::STORE_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  btta_pkg::btta_in_t  s_item,
    input  btta_pkg::btta_cmd_t cmd,
    output btta_pkg::btta_sts_t sts,
    output logic                m_valid,
    input  logic                m_ready,
    output btta_pkg::btta_out_t m_item
);
    import btta_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam int TW = AW + 2;
    localparam int XW = ((AW > SIZE_W) ? AW : SIZE_W) + 3;
    localparam int CW = ((AW + 3) > (TOT_W + 1)) ? (AW + 3) : (TOT_W + 1);

    localparam logic signed [XW-1:0] N_X    = XW'(STORE_WORDS);
    localparam logic signed [XW-1:0] NEG_N  = -N_X;
    localparam logic signed [XW-1:0] LAST_X = N_X - XW'(1);
    localparam logic signed [XW-1:0] ADM_X  = XW'(ADMIN_WORDS);
    localparam logic signed [XW-1:0] ONE_X  = XW'(1);

    localparam logic [CW-1:0] TOT_MAX   = CW'((1 << TOT_W) - 1);
    localparam logic [CW-1:0] LARGE_MAX = CW'((1 << LARGE_W) - 1);
    localparam logic [CW-1:0] HOLE_MAX  = CW'((1 << HOLE_W) - 1);

    // Clamp a tag to the store's range
    function automatic logic signed [XW-1:0] sat_tag(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = v;
        if (v > N_X) begin
            r = N_X;
        end else if (v < NEG_N) begin
            r = NEG_N;
        end
        return r;
    endfunction

    function automatic logic out_of_store(input logic signed [XW-1:0] a);
        return (a < 0) || (a >= N_X);
    endfunction

    // Working registers
    logic signed [XW-1:0] lo_reg, hi_reg, tlo_reg, thi_reg;
    logic signed [XW-1:0] start_reg, end_reg, tval_reg, sval_reg;
    logic signed [XW-1:0] size_reg, far_reg, rest_reg;
    logic                 pick_low_reg;
    logic                 oor_reg;
    logic [AW-1:0]        clr_reg;
    logic [AW+1:0]        empty_reg, used_reg;
    logic [AW:0]          holes_reg, ucnt_reg, large_reg;
    logic                 m_valid_reg;
    btta_out_t            res_reg, res_next;

    logic [TW-1:0]        ram_rdata;
    logic signed [XW-1:0] rd_val, wt, mag, lo_adv, hi_adv;
    logic signed [XW-1:0] lo_last, hi_first, raddr_s, waddr_s, wdata_s, ret_s;
    logic signed [XW-1:0] wdata_sat;
    logic [AW:0]          mag_u;
    logic                 pick_low, we;

    // Tag read back, zero outside the store; a zero tag walks as one word
    assign rd_val = oor_reg ? '0 : {{(XW-TW){ram_rdata[TW-1]}}, ram_rdata};
    assign wt     = (rd_val == 0) ? ONE_X : rd_val;
    assign mag    = (wt < 0) ? -wt : wt;
    assign mag_u  = mag[AW:0];
    assign lo_adv = lo_reg + mag;
    assign hi_adv = hi_reg - mag;

    assign lo_last  = lo_reg - tlo_reg - ONE_X;
    assign hi_first = hi_reg + thi_reg + ONE_X;
    assign pick_low = (lo_last + hi_first) < N_X;

    // Read address select
    always_comb begin
        case (cmd.rsel)
            RS_LO:        raddr_s = lo_reg;
            RS_LO_ADV:    raddr_s = lo_adv;
            RS_HI:        raddr_s = hi_reg;
            RS_HI_ADV:    raddr_s = hi_adv;
            RS_START:     raddr_s = start_reg;
            RS_END:       raddr_s = end_reg;
            RS_START_M1:  raddr_s = start_reg - ONE_X;
            RS_START_MRG: raddr_s = start_reg + rd_val;
            RS_END_P1:    raddr_s = end_reg + ONE_X;
            RS_END_MRG:   raddr_s = end_reg - rd_val;
            default:      raddr_s = lo_reg;
        endcase
    end

    // Write address and data select
    always_comb begin
        waddr_s = '0;
        wdata_s = '0;
        case (cmd.wsel)
            WS_CLEAR: begin
                waddr_s = XW'(clr_reg);
                wdata_s = (clr_reg == '0 || clr_reg == AW'(STORE_WORDS - 1)) ? NEG_N : '0;
            end
            WS_INIT_LO: begin
                waddr_s = '0;
                wdata_s = NEG_N;
            end
            WS_INIT_HI: begin
                waddr_s = LAST_X;
                wdata_s = NEG_N;
            end
            WS_FAR: begin
                waddr_s = far_reg;
                wdata_s = rest_reg;
            end
            WS_END2: begin
                waddr_s = pick_low_reg ? end_reg + ONE_X : end_reg - ONE_X;
                wdata_s = rest_reg;
            end
            WS_BASE: begin
                waddr_s = start_reg;
                wdata_s = size_reg + ADM_X;
            end
            WS_END: begin
                waddr_s = end_reg;
                wdata_s = size_reg + ADM_X;
            end
            WS_START_NEG: begin
                waddr_s = start_reg;
                wdata_s = -tval_reg;
            end
            WS_START_MERGE: begin
                waddr_s = start_reg;
                wdata_s = rd_val - tval_reg;
            end
            WS_END_SVAL: begin
                waddr_s = end_reg;
                wdata_s = sval_reg;
            end
            WS_END_MERGE: begin
                waddr_s = end_reg;
                wdata_s = rd_val + sval_reg;
            end
            WS_START_SVAL: begin
                waddr_s = start_reg;
                wdata_s = sval_reg;
            end
            default: begin
                waddr_s = '0;
                wdata_s = '0;
            end
        endcase
    end

    // Drop writes outside the store
    assign we        = (cmd.wsel != WS_NONE) && !out_of_store(waddr_s);
    assign wdata_sat = sat_tag(wdata_s);

    btta_ram #(
        .WIDTH (TW),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr_s[AW-1:0]),
        .wdata (wdata_sat[TW-1:0]),
        .raddr (raddr_s[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Remember whether the word just read lies outside the store
    always_ff @(posedge aclk) begin
        oor_reg <= out_of_store(raddr_s);
    end

    // Clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // Walk, decision and free bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            size_reg  <= XW'(s_item.req_size);
            start_reg <= XW'(s_item.block_addr) - ONE_X;
            lo_reg    <= '0;
            hi_reg    <= LAST_X;
        end
        if (cmd.lo_step) begin
            lo_reg <= lo_adv;
        end
        if (cmd.hi_step) begin
            hi_reg <= hi_adv;
        end
        if (cmd.tlo_cap) begin
            tlo_reg <= rd_val;
        end
        if (cmd.thi_cap) begin
            thi_reg <= rd_val;
        end
        if (cmd.decide) begin
            pick_low_reg <= pick_low;
            start_reg    <= pick_low ? lo_reg : hi_reg;
            end_reg      <= pick_low ? lo_reg + size_reg + ONE_X : hi_reg - size_reg - ONE_X;
            far_reg      <= pick_low ? lo_last : hi_first;
            rest_reg     <= (pick_low ? tlo_reg : thi_reg) + size_reg + ADM_X;
        end
        if (cmd.tval_cap) begin
            tval_reg <= rd_val;
            end_reg  <= start_reg + rd_val - ONE_X;
        end
        if (cmd.start_mrg) begin
            start_reg <= start_reg + rd_val;
        end
        if (cmd.end_mrg) begin
            end_reg <= end_reg - rd_val;
        end
        // Track the tag value of the freed block as the merges change it
        if (cmd.wsel == WS_START_NEG || cmd.wsel == WS_START_MERGE ||
            cmd.wsel == WS_END_MERGE) begin
            sval_reg <= out_of_store(waddr_s) ? '0 : wdata_sat;
        end
    end

    // Query statistics
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            empty_reg <= '0;
            used_reg  <= '0;
            holes_reg <= '0;
            ucnt_reg  <= '0;
            large_reg <= '0;
        end else if (cmd.q_acc) begin
            if (wt < 0) begin
                empty_reg <= empty_reg + {1'b0, mag_u};
                holes_reg <= holes_reg + (AW+1)'(1);
                if (mag_u > large_reg) begin
                    large_reg <= mag_u;
                end
            end else begin
                used_reg <= used_reg + {1'b0, mag_u};
                ucnt_reg <= ucnt_reg + (AW+1)'(1);
            end
        end
    end

    // Result fields, saturated to their widths
    logic [CW-1:0] free_c, large_c, holes_c, used_c, admin_c;
    logic [AW:0]   large_use;

    assign large_use = (large_reg > (AW+1)'(1)) ? large_reg - (AW+1)'(ADMIN_WORDS) : '0;
    assign free_c    = CW'(empty_reg);
    assign large_c   = CW'(large_use);
    assign holes_c   = CW'(holes_reg);
    assign used_c    = CW'(used_reg);
    assign admin_c   = CW'({ucnt_reg, 1'b0});
    assign ret_s     = pick_low_reg ? start_reg + ONE_X : end_reg + ONE_X;

    // Assemble the result beat
    always_comb begin
        res_next = '0;
        case (cmd.fin)
            FIN_OK: begin
                res_next.status = 1'b0;
            end
            FIN_FAIL: begin
                res_next.status = 1'b1;
            end
            FIN_ALLOC: begin
                res_next.status     = (ret_s < 0);
                res_next.alloc_addr = (ret_s < 0) ? '0 : ret_s[ADDR_W-1:0];
            end
            FIN_QUERY: begin
                res_next.free_total     = (free_c > TOT_MAX) ?
                                          TOT_MAX[TOT_W-1:0] : free_c[TOT_W-1:0];
                res_next.largest_usable = (large_c > LARGE_MAX) ?
                                          LARGE_MAX[LARGE_W-1:0] : large_c[LARGE_W-1:0];
                res_next.hole_count     = (holes_c > HOLE_MAX) ?
                                          HOLE_MAX[HOLE_W-1:0] : holes_c[HOLE_W-1:0];
                res_next.used_total     = (used_c > TOT_MAX) ?
                                          TOT_MAX[TOT_W-1:0] : used_c[TOT_W-1:0];
                res_next.admin_total    = (admin_c > TOT_MAX) ?
                                          TOT_MAX[TOT_W-1:0] : admin_c[TOT_W-1:0];
            end
            default: begin
                res_next.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_load) begin
            res_reg <= res_next;
        end
    end

    // Output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = res_reg;

    // Status to the controller
    always_comb begin
        sts             = '0;
        sts.fit         = (size_reg + ADM_X + wt) <= 0;
        sts.lo_adv_ge_n = lo_adv >= N_X;
        sts.hi_adv_le0  = hi_adv <= 0;
        sts.rd_neg      = rd_val < 0;
        sts.rd_lt2      = rd_val < ADM_X;
        sts.rd_ne_tval  = rd_val != tval_reg;
        sts.size_bad    = (size_reg < ONE_X) || (size_reg > N_X - ADM_X);
        sts.addr_bad    = (start_reg < 0) || (start_reg > N_X - XW'(3));
        sts.end_ge_n    = end_reg >= N_X;
        sts.start_pos   = start_reg > 0;
        sts.end_lt_last = end_reg < LAST_X;
        sts.split       = pick_low_reg ? (far_reg > end_reg) : (far_reg < end_reg);
        sts.out_free    = !m_valid_reg || m_ready;
        sts.clr_last    = clr_reg == AW'(STORE_WORDS - 1);
    end

endmodule

// ----- design/boundary_tag_two_ended_allocator_top.sv -----
// Boundary-tag word store allocator with two-ended first fit. Each item takes
// one action: init, allocate, free or query; one result beat per item. All tag
// reads go through the single read port of the tag RAM, one tag per cycle.
// Init rewrites both end tags. An allocate runs an upward and then a downward
// first-fit walk over the blocks and splits a remainder off when one is left;
// a query walks every block in the chain; a free checks both tags of the block
// and merges it with free neighbours. The next item can be taken in the cycle
// after the result is loaded, and a stalled output holds the result until the
// output register is free. After reset a clearing pass rebuilds the store as
// one free block; no item is accepted until it ends. A new item is taken while
// the previous result still waits at the output register.
module boundary_tag_two_ended_allocator_top #(
    parameter int STORE_WORDS = btta_pkg::STORE_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  btta_pkg::btta_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output btta_pkg::btta_out_t m_item
);
    import btta_pkg::*;

    btta_cmd_t cmd;
    btta_sts_t sts;

    btta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .action  (action_t'(s_item.action)),
        .sts     (sts),
        .cmd     (cmd)
    );

    btta_dp #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import btta_pkg::*;

    localparam int NW = 1024;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    btta_in_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    btta_out_t m_item;

    boundary_tag_two_ended_allocator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow tag store and pending results
    int        tags [NW];
    btta_out_t want_q [$];
    int        err_cnt = 0;
    bit        calm = 1'b0;
    int        live_q [$];

    function automatic int tag_rd(int a);
        if (a < 0 || a >= NW) return 0;
        return tags[a];
    endfunction

    function automatic void tag_wr(int a, int v);
        if (a < 0 || a >= NW) return;
        if (v > NW) v = NW;
        if (v < -NW) v = -NW;
        tags[a] = v;
    endfunction

    function automatic int walk_rd(int a);
        int t;
        t = tag_rd(a);
        return (t == 0) ? 1 : t;
    endfunction

    function automatic int carve(int size);
        int lo, hi, t, lo_last, hi_first, fin, rest;
        lo = 0;
        hi = NW - 1;
        if (size < 1 || size > NW - ADMIN_WORDS) return -1;
        while (lo < NW) begin
            t = walk_rd(lo);
            if (size + ADMIN_WORDS + t <= 0) break;
            lo += (t < 0) ? -t : t;
        end
        if (lo >= NW) return -1;
        while (hi > 0) begin
            t = walk_rd(hi);
            if (size + ADMIN_WORDS + t <= 0) break;
            hi -= (t < 0) ? -t : t;
        end
        hi_first = hi + tag_rd(hi) + 1;
        lo_last = lo - tag_rd(lo) - 1;
        if (lo_last + hi_first < NW) begin
            fin = lo + size + 1;
            if (lo_last > fin) begin
                rest = tag_rd(lo) + size + ADMIN_WORDS;
                tag_wr(lo_last, rest);
                tag_wr(fin + 1, rest);
            end
            tag_wr(lo, size + ADMIN_WORDS);
            tag_wr(fin, size + ADMIN_WORDS);
            return lo + 1;
        end
        fin = hi - size - 1;
        if (hi_first < fin) begin
            rest = tag_rd(hi) + size + ADMIN_WORDS;
            tag_wr(hi_first, rest);
            tag_wr(fin - 1, rest);
        end
        tag_wr(hi, size + ADMIN_WORDS);
        tag_wr(fin, size + ADMIN_WORDS);
        return fin + 1;
    endfunction

    function automatic bit release_blk(int addr);
        int st, fin, t;
        if (addr < 1 || addr > NW - ADMIN_WORDS) return 1'b0;
        st = addr - 1;
        t = tag_rd(st);
        if (t < ADMIN_WORDS) return 1'b0;
        fin = st + t - 1;
        if (fin >= NW || tag_rd(st) != tag_rd(fin)) return 1'b0;
        tag_wr(st, -tag_rd(st));
        if (st > 0 && tag_rd(st - 1) < 0) begin
            st += tag_rd(st - 1);
            tag_wr(st, tag_rd(st) - tag_rd(fin));
        end
        tag_wr(fin, tag_rd(st));
        if (fin < NW - 1 && tag_rd(fin + 1) < 0) begin
            fin -= tag_rd(fin + 1);
            tag_wr(fin, tag_rd(fin) + tag_rd(st));
            tag_wr(st, tag_rd(fin));
        end
        return 1'b1;
    endfunction

    function automatic int clip(int v, int mx);
        if (v < 0) return 0;
        return (v > mx) ? mx : v;
    endfunction

    function automatic btta_out_t predict_result(btta_in_t it);
        btta_out_t r;
        int a, idx, t, s, empty, big, holes, used, admin;
        r = '0;
        case (action_t'(it.action))
            ACT_INIT: begin
                tag_wr(0, -NW);
                tag_wr(NW - 1, -NW);
            end
            ACT_ALLOC: begin
                a = carve(int'(it.req_size));
                if (a < 0) r.status = 1'b1;
                else r.alloc_addr = a[9:0];
            end
            ACT_FREE: r.status = !release_blk(int'(it.block_addr));
            default: begin
                idx = 0; empty = 0; big = 0; holes = 0; used = 0; admin = 0;
                while (idx < NW) begin
                    t = walk_rd(idx);
                    if (t < 0) begin
                        s = -t;
                        empty += s;
                        holes++;
                        if (big < s) big = s;
                        idx += s;
                    end else begin
                        used += t;
                        admin += ADMIN_WORDS;
                        idx += t;
                    end
                end
                big = (big > 1) ? big - ADMIN_WORDS : 0;
                r.free_total     = clip(empty, 2047);
                r.largest_usable = clip(big, 1023);
                r.hole_count     = clip(holes, 1023);
                r.used_total     = clip(used, 2047);
                r.admin_total    = clip(admin, 2047);
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        err_cnt++;
    endtask

    // Drive one beat, with optional idle burst before it
    task automatic send_item(action_t act, int size, int addr);
        btta_in_t it;
        btta_out_t r;
        it.action = act;
        it.req_size = size[10:0];
        it.block_addr = addr[9:0];
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        r = predict_result(it);
        want_q.push_back(r);
        if (act == ACT_ALLOC && !r.status) live_q.push_back(int'(r.alloc_addr));
    endtask

    // Receiver stalls
    always @(posedge aclk) begin
        if (calm) m_ready <= 1'b1;
        else if ($urandom_range(0, 7) == 0) m_ready <= 1'b0;
        else m_ready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        btta_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                report("unexpected result beat", 1, 0);
            end else begin
                e = want_q.pop_front();
                if (m_item.status !== e.status) report("status", m_item.status, e.status);
                if (m_item.alloc_addr !== e.alloc_addr)
                    report("alloc_addr", m_item.alloc_addr, e.alloc_addr);
                if (m_item.free_total !== e.free_total)
                    report("free_total", m_item.free_total, e.free_total);
                if (m_item.largest_usable !== e.largest_usable)
                    report("largest_usable", m_item.largest_usable, e.largest_usable);
                if (m_item.hole_count !== e.hole_count)
                    report("hole_count", m_item.hole_count, e.hole_count);
                if (m_item.used_total !== e.used_total)
                    report("used_total", m_item.used_total, e.used_total);
                if (m_item.admin_total !== e.admin_total)
                    report("admin_total", m_item.admin_total, e.admin_total);
            end
        end
    end

    function automatic int pick_live();
        int i, a;
        i = $urandom_range(0, live_q.size() - 1);
        a = live_q[i];
        live_q.delete(i);
        return a;
    endfunction

    task automatic test_directed();
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_ALLOC, 0, 0);
        send_item(ACT_ALLOC, 1023, 0);
        send_item(ACT_ALLOC, 2047, 0);
        send_item(ACT_ALLOC, 1, 0);
        send_item(ACT_ALLOC, 5, 0);
        send_item(ACT_ALLOC, 40, 0);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_FREE, 0, 0);
        send_item(ACT_FREE, 1023, 0);
        send_item(ACT_FREE, 1022, 0);
        send_item(ACT_FREE, 500, 0);
        send_item(ACT_FREE, 1, 0);
        send_item(ACT_FREE, 1, 0);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_ALLOC, 1022, 0);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_INIT, 0, 0);
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_ALLOC, 1020, 0);
        send_item(ACT_ALLOC, 1021, 0);
        send_item(ACT_INIT, 2047, 1023);
        send_item(ACT_QUERY, 2047, 1023);
        live_q.delete();
    endtask

    // Mix of allocates, frees of live blocks, frees at bogus addresses, inits and queries
    task automatic test_random(int n);
        int k, sel, sz;
        for (k = 0; k < n; k++) begin
            if (k > n - 80) calm = 1'b1;
            sel = $urandom_range(0, 99);
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 60);
            if (sel < 45) send_item(ACT_ALLOC, sz, $urandom_range(0, 1023));
            else if (sel < 75 && live_q.size() > 0)
                send_item(ACT_FREE, $urandom_range(0, 2047), pick_live());
            else if (sel < 82) send_item(ACT_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
            else if (sel < 84) begin
                send_item(ACT_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
                live_q.delete();
            end else send_item(ACT_QUERY, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        int w;
        for (w = 0; w < NW; w++) tags[w] = 0;
        tags[0] = -NW;
        tags[NW - 1] = -NW;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(700);
        s_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_cnt == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: done, errors");
        $finish;
    end
endmodule
